// File: rtl/core/ipf_pkg.sv
// ----------------------------------------------------------------------------
// ipf_pkg: shared types and microcode for the impedance pole filter step
// Widths, register indexes, datapath select codes and the step sequence ROM.
// ----------------------------------------------------------------------------
package ipf_pkg;

  localparam int DataW             = 32;  // pressure, velocity, scalar registers
  localparam int StateW            = 48;  // auxiliary states and intermediates
  localparam int CfgW              = 64;  // widest configuration register
  localparam int CfgIdxW           = 3;   // eight registers
  localparam int PcW               = 4;   // microcode address
  localparam int POLES_DEFAULT     = 2;
  localparam int FRAC_BITS_DEFAULT = 24;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TIME_STEP   = 3'd0,
    CFG_DIRECT_GAIN = 3'd1,
    CFG_REAL_WTS    = 3'd2,
    CFG_COS_WTS     = 3'd3,
    CFG_SIN_WTS     = 3'd4,
    CFG_REAL_POLES  = 3'd5,
    CFG_POLE_RE     = 3'd6,
    CFG_POLE_IM     = 3'd7
  } cfg_reg_e;

  // Multiplier operand A (32-bit coefficient)
  typedef enum logic [2:0] {
    A_DT, A_GAIN, A_WREAL, A_WCOS, A_WSIN, A_LAM, A_ALPHA, A_BETA
  } a_sel_e;

  // Multiplier operand B (48-bit value)
  typedef enum logic [2:0] {
    B_D, B_REAL, B_COS, B_SIN, B_P
  } b_sel_e;

  // Adder left operand
  typedef enum logic [3:0] {
    X_ZERO, X_P, X_T, X_M, X_REAL, X_COS, X_SIN, X_DA, X_DB, X_DC, X_V
  } x_sel_e;

  // Adder right operand
  typedef enum logic [1:0] {
    Y_M, Y_DA, Y_DC, Y_V
  } y_sel_e;

  // Adder destination
  typedef enum logic [3:0] {
    DST_T, DST_D, DST_REAL, DST_COS, DST_SIN, DST_DA, DST_DB, DST_DC, DST_V
  } dst_e;

  typedef enum logic [1:0] {
    ST_IDLE, ST_EXEC, ST_WAIT, ST_FIN
  } state_e;

  typedef struct packed {
    logic           mul_en;
    a_sel_e         a_sel;
    b_sel_e         b_sel;
    x_sel_e         x_sel;
    y_sel_e         y_sel;
    logic           sub;
    logic           sat;
    dst_e           dst;
    logic           loop_end;
    logic [PcW-1:0] loop_start;
    logic           last;
  } uop_t;

  typedef struct packed {
    logic load_in;
    logic mul_start;
    logic apply;
    logic load_out;
    logic pole;
    uop_t uop;
  } cmd_t;

  function automatic uop_t uop_make(logic mul_en, a_sel_e a_sel, b_sel_e b_sel,
                                    x_sel_e x_sel, y_sel_e y_sel, logic sub,
                                    logic sat, dst_e dst, logic loop_end,
                                    logic [PcW-1:0] loop_start, logic last);
    uop_t u;
    u.mul_en     = mul_en;
    u.a_sel      = a_sel;
    u.b_sel      = b_sel;
    u.x_sel      = x_sel;
    u.y_sel      = y_sel;
    u.sub        = sub;
    u.sat        = sat;
    u.dst        = dst;
    u.loop_end   = loop_end;
    u.loop_start = loop_start;
    u.last       = last;
    return u;
  endfunction

  localparam logic [PcW-1:0] PcPoleLoop   = 4'd0;
  localparam logic [PcW-1:0] PcWeightLoop = 4'd8;

  // Step sequence. Steps 0-7 repeat per pole, 8-10 repeat per pole, 11-14 run once.
  function automatic uop_t uop_rom(logic [PcW-1:0] pc);
    uop_t u;
    u = uop_make(1'b0, A_DT, B_D, X_ZERO, Y_M, 1'b0, 1'b0, DST_T, 1'b0, PcPoleLoop, 1'b1);
    unique case (pc)
      // real pole: d = p + lam*r ; r += dt*d
      4'd0: u = uop_make(1'b1, A_LAM, B_REAL, X_P, Y_M, 1'b0, 1'b1, DST_D,
                         1'b0, PcPoleLoop, 1'b0);
      4'd1: u = uop_make(1'b1, A_DT, B_D, X_REAL, Y_M, 1'b0, 1'b1, DST_REAL,
                         1'b0, PcPoleLoop, 1'b0);
      // psi: d = p + alpha*c - beta*s (one saturation) ; c += dt*d
      4'd2: u = uop_make(1'b1, A_ALPHA, B_COS, X_P, Y_M, 1'b0, 1'b0, DST_T,
                         1'b0, PcPoleLoop, 1'b0);
      4'd3: u = uop_make(1'b1, A_BETA, B_SIN, X_T, Y_M, 1'b1, 1'b1, DST_D,
                         1'b0, PcPoleLoop, 1'b0);
      4'd4: u = uop_make(1'b1, A_DT, B_D, X_COS, Y_M, 1'b0, 1'b1, DST_COS,
                         1'b0, PcPoleLoop, 1'b0);
      // chi: d = beta*c' + alpha*s ; s += dt*d
      4'd5: u = uop_make(1'b1, A_BETA, B_COS, X_ZERO, Y_M, 1'b0, 1'b0, DST_T,
                         1'b0, PcPoleLoop, 1'b0);
      4'd6: u = uop_make(1'b1, A_ALPHA, B_SIN, X_T, Y_M, 1'b0, 1'b1, DST_D,
                         1'b0, PcPoleLoop, 1'b0);
      4'd7: u = uop_make(1'b1, A_DT, B_D, X_SIN, Y_M, 1'b0, 1'b1, DST_SIN,
                         1'b1, PcPoleLoop, 1'b0);
      // weighted sums
      4'd8: u = uop_make(1'b1, A_WREAL, B_REAL, X_DA, Y_M, 1'b0, 1'b1, DST_DA,
                         1'b0, PcWeightLoop, 1'b0);
      4'd9: u = uop_make(1'b1, A_WCOS, B_COS, X_DB, Y_M, 1'b0, 1'b1, DST_DB,
                         1'b0, PcWeightLoop, 1'b0);
      4'd10: u = uop_make(1'b1, A_WSIN, B_SIN, X_DC, Y_M, 1'b0, 1'b1, DST_DC,
                          1'b1, PcWeightLoop, 1'b0);
      // v = 2*(db + dc) ; v = (gain*p - da) - v
      4'd11: u = uop_make(1'b0, A_DT, B_D, X_DB, Y_DC, 1'b0, 1'b1, DST_V,
                          1'b0, PcPoleLoop, 1'b0);
      4'd12: u = uop_make(1'b0, A_DT, B_D, X_V, Y_V, 1'b0, 1'b1, DST_V,
                          1'b0, PcPoleLoop, 1'b0);
      4'd13: u = uop_make(1'b1, A_GAIN, B_P, X_M, Y_DA, 1'b1, 1'b1, DST_T,
                          1'b0, PcPoleLoop, 1'b0);
      4'd14: u = uop_make(1'b0, A_DT, B_D, X_T, Y_V, 1'b1, 1'b1, DST_V,
                          1'b0, PcPoleLoop, 1'b1);
      default: u = uop_make(1'b0, A_DT, B_D, X_ZERO, Y_M, 1'b0, 1'b0, DST_T,
                            1'b0, PcPoleLoop, 1'b1);
    endcase
    return u;
  endfunction

endpackage

// File: rtl/core/impedance_pole_filter_step.sv
// ----------------------------------------------------------------------------
// impedance_pole_filter_step: time-domain impedance boundary step
// One pressure sample in, one wall-normal velocity out, with forward-Euler
// updates of a real-pole state and a complex-pole state pair per pole.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                      Payload
//  s_axis    in         s_axis_tvalid/s_axis_tready    tdata[31:0] pressure
//  m_axis    out        m_axis_tvalid/m_axis_tready    tdata[31:0] velocity,
//                                                      tuser[0] saturated
//  cfg       in         cfg_we_i (no wait)             cfg_index_i, cfg_data_i
//
//  Every product runs through one shared multiplier: a step that uses it is
//  issued, passes four stages and is written back; adder-only steps write back
//  directly. The block takes no new sample until the current one's result is
//  registered; the next sample can be taken in the cycle after that.
//  Reset clears the configuration registers and all pole states to zero.
//  A result waiting on m_axis does not block the next sample; the sequencer
//  holds in its final step only while the output register is still occupied.
//
module impedance_pole_filter_step
  import ipf_pkg::*;
#(
  parameter int POLES     = POLES_DEFAULT,
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  // pressure samples
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [DataW-1:0]   s_axis_tdata,   // [31:0] pressure
  // velocity results
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [DataW-1:0]   m_axis_tdata,   // [31:0] velocity
  output logic               m_axis_tuser    // [0] saturated
);

  cmd_t cmd;
  logic mul_done;

  // sequencer: accepts a transaction, steps the microcode, drives the output valid
  ipf_ctrl #(
    .POLES(POLES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .mul_done_i (mul_done),
    .cmd_o      (cmd)
  );

  // datapath: registers, states, saturating adder, shared multiplier
  ipf_datapath #(
    .POLES    (POLES),
    .FRAC_BITS(FRAC_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .pressure_i (s_axis_tdata),
    .cmd_i      (cmd),
    .mul_done_o (mul_done),
    .velocity_o (m_axis_tdata),
    .saturated_o(m_axis_tuser)
  );

endmodule

// File: rtl/core/ipf_mul.sv
// ----------------------------------------------------------------------------
// ipf_mul: multi-cycle fixed-point multiplier
// Signed 32 x 48 product, scaled by 2^FRAC_BITS with rounding half away from
// zero, clipped to the signed 48-bit range.
// ----------------------------------------------------------------------------
module ipf_mul
  import ipf_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DataW-1:0]  a_i,
  input  logic [StateW-1:0] b_i,
  output logic              done_o,
  output logic [StateW-1:0] res_o,
  output logic              clip_o
);

  localparam int HalfW = StateW / 2;
  localparam int AccW  = DataW + StateW;
  localparam int RndW  = AccW - FRAC_BITS;
  localparam logic [AccW-1:0] Half = {{(AccW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic [RndW-1:0] LimPos = RndW'({1'b0, {(StateW-1){1'b1}}});
  localparam logic [RndW-1:0] LimNeg = RndW'({1'b1, {(StateW-1){1'b0}}});

  logic                    neg_q;
  logic [DataW-1:0]        ma_q;
  logic [StateW-1:0]       mb_q;
  logic [AccW-1:0]         acc_q;
  logic [RndW-1:0]         rnd_q;
  logic [3:0]              ph_q;
  logic                    done_q;
  logic [StateW-1:0]       res_q;
  logic                    clip_q;

  logic [DataW-1:0]        a_mag;
  logic [StateW-1:0]       b_mag;
  logic [DataW+HalfW-1:0]  prod_lo;
  logic [DataW+HalfW-1:0]  prod_hi;
  logic [AccW-1:0]         acc_sum;
  logic [AccW-1:0]         acc_rnd;
  logic [RndW-1:0]         lim;
  logic                    over;
  logic [StateW-1:0]       mag;

  assign a_mag   = a_i[DataW-1] ? (~a_i + DataW'(1)) : a_i;
  assign b_mag   = b_i[StateW-1] ? (~b_i + StateW'(1)) : b_i;
  assign prod_lo = ma_q * mb_q[HalfW-1:0];
  assign prod_hi = ma_q * mb_q[StateW-1:HalfW];
  assign acc_sum = acc_q + {prod_hi, {HalfW{1'b0}}};
  assign acc_rnd = acc_q + Half;
  assign lim     = neg_q ? LimNeg : LimPos;
  assign over    = rnd_q > lim;
  assign mag     = over ? lim[StateW-1:0] : rnd_q[StateW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= '0;
      done_q <= 1'b0;
    end else begin
      ph_q   <= {ph_q[2:0], start_i};
      done_q <= ph_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= a_i[DataW-1] ^ b_i[StateW-1];
      ma_q  <= a_mag;
      mb_q  <= b_mag;
    end
    if (ph_q[0]) begin
      acc_q <= AccW'(prod_lo);
    end
    if (ph_q[1]) begin
      acc_q <= acc_sum;
    end
    if (ph_q[2]) begin
      rnd_q <= acc_rnd[AccW-1:FRAC_BITS];
    end
    if (ph_q[3]) begin
      res_q  <= neg_q ? (~mag + StateW'(1)) : mag;
      clip_q <= over;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;
  assign clip_o = clip_q;

endmodule

// File: rtl/core/ipf_datapath.sv
// ----------------------------------------------------------------------------
// ipf_datapath: registers, states and arithmetic of the pole filter
// Configuration registers, auxiliary states, saturating adder, shared
// multiplier and the result register, all steered by the controller.
// ----------------------------------------------------------------------------
module ipf_datapath
  import ipf_pkg::*;
#(
  parameter int POLES     = POLES_DEFAULT,
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic [DataW-1:0]   pressure_i,
  input  cmd_t               cmd_i,
  output logic               mul_done_o,
  output logic [DataW-1:0]   velocity_o,
  output logic               saturated_o
);

  localparam int SumW = StateW + 2;
  localparam int TW   = StateW + 1;
  localparam logic [StateW-1:0] Max48 = {1'b0, {(StateW-1){1'b1}}};
  localparam logic [StateW-1:0] Min48 = {1'b1, {(StateW-1){1'b0}}};
  localparam logic [DataW-1:0]  Max32 = {1'b0, {(DataW-1){1'b1}}};
  localparam logic [DataW-1:0]  Min32 = {1'b1, {(DataW-1){1'b0}}};

  function automatic logic [DataW-1:0] lane(logic [CfgW-1:0] v, logic sel);
    return sel ? v[CfgW-1:DataW] : v[DataW-1:0];
  endfunction

  // configuration
  logic [DataW-1:0]  dt_q, gain_q;
  logic [CfgW-1:0]   wreal_q, wcos_q, wsin_q, lam_q, alpha_q, beta_q;

  // state and working registers
  logic [StateW-1:0] real_q [POLES];
  logic [StateW-1:0] cos_q  [POLES];
  logic [StateW-1:0] sin_q  [POLES];
  logic [DataW-1:0]  p_q;
  logic [StateW-1:0] d_q, da_q, db_q, dc_q, v_q;
  logic [TW-1:0]     t_q;
  logic              clip_q;
  logic [DataW-1:0]  vel_q;
  logic              usat_q;

  logic [DataW-1:0]  op_a;
  logic [StateW-1:0] op_b;
  logic [StateW-1:0] m;
  logic              m_clip;
  logic [SumW-1:0]   x, y, sum;
  logic              in_range;
  logic [StateW-1:0] sat_val;
  logic              v_in32;

  ipf_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.mul_start),
    .a_i    (op_a),
    .b_i    (op_b),
    .done_o (mul_done_o),
    .res_o  (m),
    .clip_o (m_clip)
  );

  always_comb begin
    unique case (cmd_i.uop.a_sel)
      A_DT:    op_a = dt_q;
      A_GAIN:  op_a = gain_q;
      A_WREAL: op_a = lane(wreal_q, cmd_i.pole);
      A_WCOS:  op_a = lane(wcos_q, cmd_i.pole);
      A_WSIN:  op_a = lane(wsin_q, cmd_i.pole);
      A_LAM:   op_a = lane(lam_q, cmd_i.pole);
      A_ALPHA: op_a = lane(alpha_q, cmd_i.pole);
      A_BETA:  op_a = lane(beta_q, cmd_i.pole);
    endcase
  end

  always_comb begin
    unique case (cmd_i.uop.b_sel)
      B_D:     op_b = d_q;
      B_REAL:  op_b = real_q[cmd_i.pole];
      B_COS:   op_b = cos_q[cmd_i.pole];
      B_SIN:   op_b = sin_q[cmd_i.pole];
      B_P:     op_b = StateW'(signed'(p_q));
      default: op_b = d_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.uop.x_sel)
      X_ZERO:  x = '0;
      X_P:     x = SumW'(signed'(p_q));
      X_T:     x = SumW'(signed'(t_q));
      X_M:     x = SumW'(signed'(m));
      X_REAL:  x = SumW'(signed'(real_q[cmd_i.pole]));
      X_COS:   x = SumW'(signed'(cos_q[cmd_i.pole]));
      X_SIN:   x = SumW'(signed'(sin_q[cmd_i.pole]));
      X_DA:    x = SumW'(signed'(da_q));
      X_DB:    x = SumW'(signed'(db_q));
      X_DC:    x = SumW'(signed'(dc_q));
      X_V:     x = SumW'(signed'(v_q));
      default: x = '0;
    endcase
  end

  always_comb begin
    unique case (cmd_i.uop.y_sel)
      Y_M:  y = SumW'(signed'(m));
      Y_DA: y = SumW'(signed'(da_q));
      Y_DC: y = SumW'(signed'(dc_q));
      Y_V:  y = SumW'(signed'(v_q));
    endcase
  end

  assign sum      = cmd_i.uop.sub ? (x - y) : (x + y);
  assign in_range = (sum[SumW-1:StateW-1] == 3'b000) || (sum[SumW-1:StateW-1] == 3'b111);
  assign sat_val  = in_range ? sum[StateW-1:0] : (sum[SumW-1] ? Min48 : Max48);
  assign v_in32   = (v_q[StateW-1:DataW-1] == '0) || (v_q[StateW-1:DataW-1] == '1);

  // configuration writes; scalar registers keep the low word only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q    <= '0;
      gain_q  <= '0;
      wreal_q <= '0;
      wcos_q  <= '0;
      wsin_q  <= '0;
      lam_q   <= '0;
      alpha_q <= '0;
      beta_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_TIME_STEP:   dt_q    <= cfg_data_i[DataW-1:0];
        CFG_DIRECT_GAIN: gain_q  <= cfg_data_i[DataW-1:0];
        CFG_REAL_WTS:    wreal_q <= cfg_data_i;
        CFG_COS_WTS:     wcos_q  <= cfg_data_i;
        CFG_SIN_WTS:     wsin_q  <= cfg_data_i;
        CFG_REAL_POLES:  lam_q   <= cfg_data_i;
        CFG_POLE_RE:     alpha_q <= cfg_data_i;
        CFG_POLE_IM:     beta_q  <= cfg_data_i;
      endcase
    end
  end

  // auxiliary states and the sticky clip flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < POLES; i++) begin
        real_q[i] <= '0;
        cos_q[i]  <= '0;
        sin_q[i]  <= '0;
      end
      clip_q <= 1'b0;
    end else begin
      if (cmd_i.load_in) begin
        clip_q <= 1'b0;
      end else if (cmd_i.apply) begin
        clip_q <= clip_q | (cmd_i.uop.mul_en & m_clip) | (cmd_i.uop.sat & ~in_range);
        unique case (cmd_i.uop.dst)
          DST_REAL: real_q[cmd_i.pole] <= sat_val;
          DST_COS:  cos_q[cmd_i.pole]  <= sat_val;
          DST_SIN:  sin_q[cmd_i.pole]  <= sat_val;
          default: ;
        endcase
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      p_q  <= pressure_i;
      da_q <= '0;
      db_q <= '0;
      dc_q <= '0;
    end else if (cmd_i.apply) begin
      unique case (cmd_i.uop.dst)
        DST_T:   t_q  <= cmd_i.uop.sat ? TW'(signed'(sat_val)) : sum[TW-1:0];
        DST_D:   d_q  <= sat_val;
        DST_DA:  da_q <= sat_val;
        DST_DB:  db_q <= sat_val;
        DST_DC:  dc_q <= sat_val;
        DST_V:   v_q  <= sat_val;
        default: ;
      endcase
    end
    if (cmd_i.load_out) begin
      vel_q  <= v_in32 ? v_q[DataW-1:0] : (v_q[StateW-1] ? Min32 : Max32);
      usat_q <= clip_q | ~v_in32;
    end
  end

  assign velocity_o  = vel_q;
  assign saturated_o = usat_q;

endmodule

// File: rtl/core/ipf_ctrl.sv
// ----------------------------------------------------------------------------
// ipf_ctrl: sequencer of the pole filter step
// Accepts a sample, walks the step ROM over all poles, waits on the shared
// multiplier and hands the result to the output register.
// ----------------------------------------------------------------------------
module ipf_ctrl
  import ipf_pkg::*;
#(
  parameter int POLES = POLES_DEFAULT
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  logic mul_done_i,
  output cmd_t cmd_o
);

  localparam logic LastPole = 1'(POLES - 1);

  state_e         state_q, state_d;
  logic [PcW-1:0] pc_q, pc_d;
  logic           pole_q, pole_d;
  logic           out_valid_q, out_valid_d;
  uop_t           uop;
  logic           advance;

  assign uop = uop_rom(pc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      pole_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      pole_q      <= pole_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    pc_d            = pc_q;
    pole_d          = pole_q;
    out_valid_d     = out_valid_q & ~out_ready_i;
    advance         = 1'b0;
    in_ready_o      = 1'b0;
    cmd_o.load_in   = 1'b0;
    cmd_o.mul_start = 1'b0;
    cmd_o.apply     = 1'b0;
    cmd_o.load_out  = 1'b0;
    cmd_o.pole      = pole_q;
    cmd_o.uop       = uop;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) begin
          pc_d    = '0;
          pole_d  = 1'b0;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (uop.mul_en) begin
          cmd_o.mul_start = 1'b1;
          state_d         = ST_WAIT;
        end else begin
          cmd_o.apply = 1'b1;
          advance     = 1'b1;
        end
      end
      ST_WAIT: begin
        if (mul_done_i) begin
          cmd_o.apply = 1'b1;
          advance     = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
    endcase

    if (advance) begin
      priority if (uop.last) begin
        pc_d    = '0;
        state_d = ST_FIN;
      end else if (uop.loop_end && (pole_q != LastPole)) begin
        pole_d = pole_q + 1'b1;
        pc_d   = uop.loop_start;
      end else if (uop.loop_end) begin
        pole_d = 1'b0;
        pc_d   = pc_q + 1'b1;
      end else begin
        pc_d = pc_q + 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: dv/impedance_pole_filter_step_tb.sv
// ----------------------------------------------------------------------------
// impedance_pole_filter_step_tb: self-checking bench for the pole filter step
// Streams pressure samples into the block under a range of register settings,
// predicts every velocity and saturation flag with a fixed-point copy of the
// pole update, and compares each result as it leaves the master side.
// ----------------------------------------------------------------------------
module impedance_pole_filter_step_tb;
  import ipf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     NumPoles  = POLES_DEFAULT;
  localparam int     FracBits  = FRAC_BITS_DEFAULT;
  localparam longint Max48     = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint Min48     = -Max48 - 1;
  localparam int     IdleLimit = 20000;  // cycles without any transaction
  localparam int     MaxPrints = 40;

  typedef struct packed {
    logic [DataW-1:0] velocity;
    logic             saturated;
  } velocity_result_t;

  // --------------------------------------------------------------------------
  // DUT signals
  // --------------------------------------------------------------------------
  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_we_i      = 1'b0;
  cfg_reg_e         cfg_index_i   = CFG_TIME_STEP;
  logic [CfgW-1:0]  cfg_data_i    = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [DataW-1:0] s_axis_tdata  = '0;  // [31:0] pressure
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [DataW-1:0] m_axis_tdata;        // [31:0] velocity
  logic             m_axis_tuser;        // [0] saturated

  impedance_pole_filter_step #(
    .POLES    (NumPoles),
    .FRAC_BITS(FracBits)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Filter predictor: register shadow, pole states and the fixed-point ops
  // --------------------------------------------------------------------------
  logic [CfgW-1:0]          cfg_shadow [8];
  logic signed [StateW-1:0] real_st [NumPoles];
  logic signed [StateW-1:0] cos_st  [NumPoles];
  logic signed [StateW-1:0] sin_st  [NumPoles];
  logic                     step_clipped;

  // Signed 32-bit lane i of a packed register.
  function automatic longint coef(cfg_reg_e r, int i);
    logic signed [31:0] l;
    l = cfg_shadow[r][32*i +: 32];
    return longint'(l);
  endfunction

  function automatic longint clip48(longint v);
    if (v > Max48) begin
      step_clipped = 1'b1;
      return Max48;
    end
    if (v < Min48) begin
      step_clipped = 1'b1;
      return Min48;
    end
    return v;
  endfunction

  // Exact product, scaled by 2^FracBits with round half away from zero on the
  // magnitude, then clipped to the 48-bit range.
  function automatic longint fx_mul(longint a, longint b);
    logic         neg;
    logic [63:0]  ma, mb;
    logic [127:0] mag, lim;
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? -a : a;
    mb  = (b < 0) ? -b : b;
    mag = {64'd0, ma} * {64'd0, mb};
    mag = (mag + (128'd1 << (FracBits - 1))) >> FracBits;
    lim = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
    if (mag > lim) begin
      step_clipped = 1'b1;
      mag = lim;
    end
    return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
  endfunction

  // Advance every pole by one Euler step and form the velocity.
  function automatic velocity_result_t filter_step(logic [DataW-1:0] p_bits);
    velocity_result_t res;
    logic signed [31:0] p32;
    longint p, dt, r0, c0, s0, c1, d, da, db, dc, v;
    p32 = p_bits;
    p   = longint'(p32);
    dt  = coef(CFG_TIME_STEP, 0);
    da  = 0;
    db  = 0;
    dc  = 0;
    step_clipped = 1'b0;
    for (int i = 0; i < NumPoles; i++) begin
      r0 = real_st[i];
      c0 = cos_st[i];
      s0 = sin_st[i];
      d = clip48(p + fx_mul(coef(CFG_REAL_POLES, i), r0));
      real_st[i] = clip48(r0 + fx_mul(dt, d));
      // psi: both products enter one saturated sum
      d = clip48(p + fx_mul(coef(CFG_POLE_RE, i), c0) - fx_mul(coef(CFG_POLE_IM, i), s0));
      c1 = clip48(c0 + fx_mul(dt, d));
      cos_st[i] = c1;
      // chi sees the psi value already advanced in this step
      d = clip48(fx_mul(coef(CFG_POLE_IM, i), c1) + fx_mul(coef(CFG_POLE_RE, i), s0));
      sin_st[i] = clip48(s0 + fx_mul(dt, d));
    end
    for (int i = 0; i < NumPoles; i++) begin
      da = clip48(da + fx_mul(coef(CFG_REAL_WTS, i), real_st[i]));
      db = clip48(db + fx_mul(coef(CFG_COS_WTS, i), cos_st[i]));
      dc = clip48(dc + fx_mul(coef(CFG_SIN_WTS, i), sin_st[i]));
    end
    v = clip48(db + dc);
    v = clip48(v + v);
    v = clip48(clip48(fx_mul(coef(CFG_DIRECT_GAIN, 0), p) - da) - v);
    if (v > longint'(32'sh7FFF_FFFF)) begin
      step_clipped = 1'b1;
      v = longint'(32'sh7FFF_FFFF);
    end
    if (v < -longint'(64'sh8000_0000)) begin
      step_clipped = 1'b1;
      v = -longint'(64'sh8000_0000);
    end
    res.velocity  = v[31:0];
    res.saturated = step_clipped;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Bookkeeping shared by the processes
  // --------------------------------------------------------------------------
  logic [DataW-1:0] pressure_q[$];      // every sample to send, in order
  velocity_result_t velocity_due_q[$];  // predictions not yet seen on m_axis
  logic [CfgW-1:0]  next_regs [8];
  int               accepted_count  = 0;
  int               results_checked = 0;
  int               saturated_seen  = 0;
  int               mismatch_count  = 0;
  int               settings_used   = 0;
  int               longest_hold    = 0;

  task automatic report_mismatch(string what, logic [DataW-1:0] got,
                                 logic [DataW-1:0] want);
    mismatch_count++;
    if (mismatch_count <= MaxPrints)
      $display("MISMATCH %s at result %0d: got %h want %h", what, results_checked,
               got, want);
  endtask

  // --------------------------------------------------------------------------
  // Driver: offer pending samples in bursts with random gaps between them
  // --------------------------------------------------------------------------
  int offer_idx  = -1;
  int gap_left   = 0;
  int burst_left = 1;

  always @(negedge clk_i) begin
    // Hold an offered sample until the monitor counts it as taken.
    if (rst_ni && !(s_axis_tvalid && accepted_count == offer_idx)) begin
      if (gap_left != 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= $urandom;
      end else if (accepted_count < pressure_q.size()) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pressure_q[accepted_count];
        offer_idx     = accepted_count;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          case ($urandom_range(0, 9))
            0, 1, 2, 3: gap_left = 0;
            4, 5, 6, 7: gap_left = $urandom_range(1, 20);
            default:    gap_left = $urandom_range(21, 300);
          endcase
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall on a rotating pattern, with occasional long hold-offs
  // --------------------------------------------------------------------------
  int          rx_cycle    = 0;
  int          hold_left   = 0;
  logic [15:0] rx_pattern  = 16'hFFFF;
  logic        forced_hold = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      rx_cycle++;
      if (rx_cycle % 512 == 0)
        rx_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      // One forced hold-off early in the random part, rare ones after that;
      // the sender keeps offering so the block backs up and drops tready.
      if (hold_left == 0 && ((!forced_hold && accepted_count == 40) ||
                             $urandom_range(0, 19999) == 0)) begin
        forced_hold = 1'b1;
        hold_left = $urandom_range(1500, 3000);
        if (hold_left > longest_hold) longest_hold = hold_left;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= rx_pattern[rx_cycle % 16];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: shadow register writes, predict on input, check on output
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    velocity_result_t due;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_TIME_STEP || cfg_index_i == CFG_DIRECT_GAIN)
          cfg_shadow[cfg_index_i] = {32'd0, cfg_data_i[31:0]};
        else
          cfg_shadow[cfg_index_i] = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        velocity_due_q.push_back(filter_step(s_axis_tdata));
        accepted_count++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (velocity_due_q.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata, '0);
        end else begin
          due = velocity_due_q.pop_front();
          if (m_axis_tdata !== due.velocity)
            report_mismatch("velocity", m_axis_tdata, due.velocity);
          if (m_axis_tuser !== due.saturated)
            report_mismatch("saturated", 32'(m_axis_tuser), 32'(due.saturated));
          if (due.saturated) saturated_seen++;
        end
        results_checked++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when no transaction moves for too long
  // --------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no transaction for %0d cycles", IdleLimit);
        $display("impedance_pole_filter_step verification failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic logic [31:0] rand_lane(int unsigned span);
    return 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  // Stable-looking lane: zero or negative.
  function automatic logic [31:0] neg_lane(int unsigned span);
    return 32'd0 - 32'($urandom_range(0, span));
  endfunction

  function automatic logic [31:0] rand_pressure();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return rand_lane(1 << 26);
      4, 5:       return $urandom;
      6:          return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default:    return '0;
    endcase
  endfunction

  // Write all eight registers back to back, then drop the write enable.
  task automatic program_regs();
    for (int r = 0; r < 8; r++) begin
      @(negedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_index_i <= cfg_reg_e'(r);
      cfg_data_i  <= next_regs[r];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Wait until every queued sample is in and every prediction is matched.
  task automatic drain();
    while (accepted_count < pressure_q.size() || velocity_due_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] corner_p [5];
    corner_p = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h8000_0000};
    foreach (cfg_shadow[r]) cfg_shadow[r] = '0;
    for (int i = 0; i < NumPoles; i++) begin
      real_st[i] = '0;
      cos_st[i]  = '0;
      sin_st[i]  = '0;
    end

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: every register is zero, so velocity stays zero.
    pressure_q.push_back(32'h0);
    pressure_q.push_back(32'h7FFF_FFFF);
    pressure_q.push_back(32'h8000_0000);
    pressure_q.push_back(32'hFFFF_FFFF);
    drain();

    // Nominal poles; upper halves of the scalar registers carry junk to mask.
    next_regs[CFG_TIME_STEP]   = 64'hDEAD_BEEF_0004_0000;
    next_regs[CFG_DIRECT_GAIN] = 64'hA5A5_5A5A_0080_0000;
    next_regs[CFG_REAL_WTS]    = 64'hFF00_0000_0100_0000;
    next_regs[CFG_COS_WTS]     = 64'h0200_0000_0080_0000;
    next_regs[CFG_SIN_WTS]     = 64'hFFC0_0000_0040_0000;
    next_regs[CFG_REAL_POLES]  = 64'hF800_0000_FC00_0000;
    next_regs[CFG_POLE_RE]     = 64'hFE00_0000_FF00_0000;
    next_regs[CFG_POLE_IM]     = 64'hFA00_0000_0400_0000;
    program_regs();
    pressure_q.push_back(32'h7FFF_FFFF);
    pressure_q.push_back(32'h8000_0000);
    pressure_q.push_back(32'h0);
    pressure_q.push_back(32'h1);
    pressure_q.push_back(32'hFFFF_FFFF);
    pressure_q.push_back(32'h0100_0000);
    pressure_q.push_back(32'hFF00_0000);
    // zero input lets the states decay on their own
    repeat (3) pressure_q.push_back(32'h0);
    drain();

    // Largest positive coefficients: states and velocity clip at once.
    foreach (next_regs[r]) next_regs[r] = {32'hFFFF_FFFF, 32'h7FFF_FFFF};
    foreach (next_regs[r]) if (r >= CFG_REAL_WTS) next_regs[r] = 64'h7FFF_FFFF_7FFF_FFFF;
    program_regs();
    foreach (corner_p[k]) pressure_q.push_back(corner_p[k]);
    drain();

    // Most negative coefficients in every lane.
    foreach (next_regs[r]) next_regs[r] = 64'h8000_0000_8000_0000;
    program_regs();
    foreach (corner_p[k]) pressure_q.push_back(corner_p[k]);
    drain();

    // Random part: moderate poles, wide step sizes, and fully random words.
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 3)
        0, 1: begin
          next_regs[CFG_TIME_STEP] = {$urandom, (ph % 3 == 0) ?
                                      32'($urandom_range(1 << 10, 1 << 20)) :
                                      rand_lane(1 << 26)};
          next_regs[CFG_DIRECT_GAIN] = {$urandom, rand_lane(1 << 25)};
          next_regs[CFG_REAL_WTS]    = {rand_lane(1 << 26), rand_lane(1 << 26)};
          next_regs[CFG_COS_WTS]     = {rand_lane(1 << 26), rand_lane(1 << 26)};
          next_regs[CFG_SIN_WTS]     = {rand_lane(1 << 26), rand_lane(1 << 26)};
          next_regs[CFG_REAL_POLES]  = {neg_lane(1 << 28), neg_lane(1 << 28)};
          next_regs[CFG_POLE_RE]     = {neg_lane(1 << 28), neg_lane(1 << 28)};
          next_regs[CFG_POLE_IM]     = {rand_lane(1 << 28), rand_lane(1 << 28)};
        end
        default: begin
          foreach (next_regs[r]) next_regs[r] = {$urandom, $urandom};
        end
      endcase
      program_regs();
      repeat (118) pressure_q.push_back(rand_pressure());
      drain();
    end

    // Let any stray result show up before the verdict.
    repeat (300) @(posedge clk_i);
    if (velocity_due_q.size() != 0)
      report_mismatch("missing result", '0, velocity_due_q[0].velocity);

    $display("sent %0d pressure samples under %0d register settings, checked %0d results",
             pressure_q.size(), settings_used, results_checked);
    $display("%0d results saturated, longest receiver hold-off %0d cycles",
             saturated_seen, longest_hold);
    if (mismatch_count == 0) begin
      $display("impedance_pole_filter_step verification clean");
    end else begin
      $display("impedance_pole_filter_step verification failed");
    end
    $finish;
  end

endmodule
